>>> hw/rtl/frr_pkg.sv
// Shared constants for the frequency rank relabel unit.
package frr_pkg;

    // Action codes carried on the input channel.
    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_COUNT   = 2'd1;
    localparam logic [1:0] ACT_RELABEL = 2'd2;

    // Configuration register map.
    localparam int unsigned PADDR_W        = 2;
    localparam logic [1:0]  ADDR_SPECIES   = 2'd0;
    localparam int unsigned SPECIES_W      = 7;
    localparam logic [6:0]  SPECIES_RESET  = 7'd64;

    // Field widths of the item channels.
    localparam int unsigned LABEL_W = 7;
    localparam int unsigned RANK_W  = 7;

endpackage

>>> hw/rtl/frequency_rank_relabel_unit.sv
// Frequency rank relabel unit: label histogram in a synchronous memory with rank lookup.
//
// Usage. Items arrive on the s_ channel (s_action, s_cell_label) with valid/ready
// and results leave on the m_ channel (m_rank_label) with valid/ready. A clear
// item empties the histogram, a count item adds one to its label's count
// (saturating at MAX_CELLS), and a relabel item returns one result: the rank of
// its label, 1 for the most abundant, ties going to the lower label number, and
// 0 for label 0, a label above min(species_in_use, MAX_SPECIES) or a label never counted.
// Only relabel items produce results; clear, count and unused actions produce none.
// Timing. A count item is accepted, its entry read from memory and written back. A clear
// item sweeps the histogram after it is accepted, one histogram entry is zeroed per cycle.
// A relabel item reads its label's own count and then scans the histogram, because
// the single memory read port visits every valid entry (up to min(species_in_use,
// MAX_SPECIES)) once while comparing it against the label's own count; out-of-range labels
// skip the memory, and labels never counted skip the scan. One item is worked on at a time.
// Reset. After aresetn the same clearing pass runs over every entry with
// s_ready low; species_in_use returns to 64. The APB port stays writable.
// Stalls. The result sits in an output register, so the unit keeps taking and
// finishing clear and count items while m_ready is low; a second relabel waits
// for the output register to empty before it presents its result.
module frequency_rank_relabel_unit #(
    parameter int unsigned MAX_SPECIES = 64,
    parameter int unsigned MAX_CELLS   = 65536
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // APB-style configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [frr_pkg::PADDR_W-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // input item channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_action,
    input  logic [frr_pkg::LABEL_W-1:0]         s_cell_label,
    // result item channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [frr_pkg::RANK_W-1:0]          m_rank_label
);

    localparam int unsigned AW    = $clog2(MAX_SPECIES);
    localparam int unsigned LIM_W = $clog2(MAX_SPECIES + 1);
    localparam int unsigned CNT_W = $clog2(MAX_CELLS + 1);
    localparam int unsigned CMP_W = (LIM_W > frr_pkg::SPECIES_W) ? LIM_W : frr_pkg::SPECIES_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CNT_RD,
        S_CNT_WR,
        S_RK_RD,
        S_RK_SELF,
        S_RK_SCAN,
        S_DONE
    } state_t;

    // Registers and their next values.
    state_t                             state_reg, state_next;
    logic [frr_pkg::SPECIES_W-1:0]      species_reg, species_next;
    logic [AW-1:0]                      idx_reg, idx_next;       // clear sweep / scan index
    logic [AW-1:0]                      lbl_idx_reg, lbl_idx_next;
    logic [CNT_W-1:0]                   mine_reg, mine_next;
    logic [LIM_W-1:0]                   rank_reg, rank_next;
    logic                               m_valid_reg, m_valid_next;
    logic [frr_pkg::RANK_W-1:0]         m_rank_reg, m_rank_next;

    // Histogram memory with one registered read port and one write port.
    logic [CNT_W-1:0]                   count_mem [MAX_SPECIES];
    logic [CNT_W-1:0]                   rd_data_reg;
    logic [AW-1:0]                      rd_addr;
    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    logic [CNT_W-1:0]                   wr_data;

    logic [CMP_W-1:0]                   species_ext;
    logic [LIM_W-1:0]                   lim;
    logic                               label_ok;
    logic                               cfg_write;
    logic                               s_fire;
    logic                               last_scan;
    logic                               beats;

    // Valid label limit: species_in_use saturated to MAX_SPECIES.
    assign species_ext = CMP_W'(species_reg);
    assign lim = (species_ext > CMP_W'(MAX_SPECIES)) ? LIM_W'(MAX_SPECIES)
                                                     : LIM_W'(species_ext);
    assign label_ok = (s_cell_label != '0) && (CMP_W'(s_cell_label) <= CMP_W'(lim));

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr == frr_pkg::ADDR_SPECIES) ? 32'(species_reg) : 32'd0;

    assign s_ready      = (state_reg == S_IDLE);
    assign s_fire       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_rank_label = m_rank_reg;

    assign last_scan = ((LIM_W'(idx_reg) + LIM_W'(1)) == lim);
    // The entry now on the read port outranks the label's own count.
    assign beats = (rd_data_reg > mine_reg)
                || ((rd_data_reg == mine_reg) && (idx_reg < lbl_idx_reg));

    // Read address follows the state so that the data is registered into rd_data_reg for the following state.
    always_comb begin
        case (state_reg)
            S_RK_SELF: rd_addr = '0;
            S_RK_SCAN: rd_addr = idx_reg + AW'(1);
            default:   rd_addr = lbl_idx_reg;
        endcase
    end

    // Write port: zeroing during a clear sweep, saturating increment on a count.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = lbl_idx_reg;
        wr_data = '0;
        if (state_reg == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = idx_reg;
        end else if (state_reg == S_CNT_WR) begin
            wr_en   = (rd_data_reg < CNT_W'(MAX_CELLS));
            wr_data = rd_data_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            count_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= count_mem[rd_addr];
    end

    always_comb begin
        state_next   = state_reg;
        species_next = species_reg;
        idx_next     = idx_reg;
        lbl_idx_next = lbl_idx_reg;
        mine_next    = mine_reg;
        rank_next    = rank_reg;
        m_valid_next = m_valid_reg;
        m_rank_next  = m_rank_reg;

        if (cfg_write && (paddr == frr_pkg::ADDR_SPECIES)) begin
            species_next = pwdata[frr_pkg::SPECIES_W-1:0];
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                idx_next = idx_reg + AW'(1);
                if (idx_reg == AW'(MAX_SPECIES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    lbl_idx_next = AW'(s_cell_label - frr_pkg::LABEL_W'(1));
                    case (s_action)
                        frr_pkg::ACT_CLEAR: begin
                            idx_next   = '0;
                            state_next = S_CLEAR;
                        end
                        frr_pkg::ACT_COUNT: begin
                            if (label_ok) begin
                                state_next = S_CNT_RD;
                            end
                        end
                        frr_pkg::ACT_RELABEL: begin
                            rank_next  = '0;
                            state_next = label_ok ? S_RK_RD : S_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            S_CNT_RD:  state_next = S_CNT_WR;
            S_CNT_WR:  state_next = S_IDLE;
            S_RK_RD:   state_next = S_RK_SELF;
            S_RK_SELF: begin
                mine_next = rd_data_reg;
                idx_next  = '0;
                if (rd_data_reg == '0) begin
                    rank_next  = '0;
                    state_next = S_DONE;
                end else begin
                    rank_next  = LIM_W'(1);
                    state_next = S_RK_SCAN;
                end
            end
            S_RK_SCAN: begin
                if (beats) begin
                    rank_next = rank_reg + LIM_W'(1);
                end
                idx_next = idx_reg + AW'(1);
                if (last_scan) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_rank_next  = frr_pkg::RANK_W'(rank_reg);
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            species_reg <= frr_pkg::SPECIES_RESET;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            species_reg <= species_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
        lbl_idx_reg <= lbl_idx_next;
        mine_reg    <= mine_next;
        rank_reg    <= rank_next;
        m_rank_reg  <= m_rank_next;
    end

    // A clear item always starts a sweep, during which no item is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_action == frr_pkg::ACT_CLEAR)) |=> (state_reg == S_CLEAR) && !s_ready)
        else $error("clear item did not start the clearing sweep");

    // A result only appears when a relabel finishes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside relabel completion");

    // Count writes never go past the saturation limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && (state_reg == S_CNT_WR)) |-> (wr_data <= CNT_W'(MAX_CELLS)))
        else $error("histogram count exceeded MAX_CELLS");

endmodule
